### rtl/core/csmc_pkg.sv
// package for the color sensor measure/classify block
// holds register indexes, reset values, operation and result codes, shared types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package csmc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int REG_W     = 16;
  localparam int SUM_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_PERIOD   = 3'd0,
    CFG_GREEN_SLOPE  = 3'd1,
    CFG_GREEN_OFFSET = 3'd2,
    CFG_GREEN_FLOOR  = 3'd3,
    CFG_RED_SLOPE    = 3'd4,
    CFG_RED_OFFSET   = 3'd5,
    CFG_RED_FLOOR    = 3'd6
  } cfg_reg_t;

  localparam logic [REG_W-1:0] RST_MAX_PERIOD = 16'd50000;
  localparam logic [REG_W-1:0] RST_SLOPE      = 16'd1;
  localparam logic [REG_W-1:0] RST_OFFSET     = 16'd1;
  localparam logic [REG_W-1:0] RST_FLOOR      = 16'd1;

  typedef enum logic [1:0] {
    OP_GREEN  = 2'd0,
    OP_RED    = 2'd1,
    OP_SWITCH = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  localparam logic EVENT_SWITCH = 1'b0;
  localparam logic EVENT_FINISH = 1'b1;

  localparam logic [1:0] VERDICT_GREEN = 2'd0;
  localparam logic [1:0] VERDICT_RED   = 2'd1;
  localparam logic [1:0] VERDICT_AGAIN = 2'd2;

  // event queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // mean by reciprocal multiply: high half products, then the final add
  localparam int DIV_STEPS = 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic             kind;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] red_sum;
  } event_t;

  typedef struct packed {
    logic               valid;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_LOAD = 2'd2
  } bk_state_t;

endpackage
`default_nettype wire

### rtl/core/csmc_front.sv
// front part: config registers, period extraction, run sequencing, scaling and sums
// pushes switch/finish events into the event queue; depends on csmc_pkg
`timescale 1ns / 1ps
`default_nettype none
module csmc_front
  import csmc_pkg::*;
#(
  parameter int SAMPLES = 16,
  parameter int DISCARD = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [REG_W-1:0]     in_capture_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data,
  input  wire q_status_t            q_status,
  output logic                      ev_push,
  output event_t                    ev_data
);

  localparam int IDX_W = $clog2(SAMPLES + 1);
  localparam int HALF  = SAMPLES / 2;

  logic [REG_W-1:0] max_period_r, green_slope_r, green_offset_r, green_floor_r;
  logic [REG_W-1:0] red_slope_r, red_offset_r, red_floor_r;

  logic [REG_W-1:0] first_r, second_r, first_nxt, second_nxt;
  logic             toggle_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SUM_W-1:0] green_sum_r, red_sum_r, green_sum_nxt, red_sum_nxt;

  logic             accept;
  logic [REG_W-1:0] period, clamped, floor_sel;
  logic             reject;
  op_t              op_sel;
  logic             add_sel;
  logic [REG_W-1:0] slope_sel, offset_sel;

  // stage 1: operands for scaling
  logic             s1_valid_r;
  op_t              s1_op_r;
  logic             s1_add_r;
  logic [REG_W-1:0] s1_p_r, s1_slope_r, s1_offset_r;

  // stage 2: scaled value
  logic             s2_valid_r;
  op_t              s2_op_r;
  logic             s2_add_r;
  logic [SUM_W-1:0] s2_scaled_r;

  logic             s1_ev, s2_ev;
  logic [Q_CNT_W:0] pending;
  logic             s2_green;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_period_r   <= RST_MAX_PERIOD;
      green_slope_r  <= RST_SLOPE;
      green_offset_r <= RST_OFFSET;
      green_floor_r  <= RST_FLOOR;
      red_slope_r    <= RST_SLOPE;
      red_offset_r   <= RST_OFFSET;
      red_floor_r    <= RST_FLOOR;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_PERIOD:   max_period_r   <= cfg_data;
        CFG_GREEN_SLOPE:  green_slope_r  <= cfg_data;
        CFG_GREEN_OFFSET: green_offset_r <= cfg_data;
        CFG_GREEN_FLOOR:  green_floor_r  <= cfg_data;
        CFG_RED_SLOPE:    red_slope_r    <= cfg_data;
        CFG_RED_OFFSET:   red_offset_r   <= cfg_data;
        CFG_RED_FLOOR:    red_floor_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // reserve queue room for every event still in the pipe
  assign s1_ev   = s1_valid_r && (s1_op_r == OP_SWITCH || s1_op_r == OP_FINISH);
  assign s2_ev   = s2_valid_r && (s2_op_r == OP_SWITCH || s2_op_r == OP_FINISH);
  assign pending = {1'b0, q_status.count} + (Q_CNT_W + 1)'(s1_ev) + (Q_CNT_W + 1)'(s2_ev);
  assign in_stall = (pending >= (Q_CNT_W + 1)'(Q_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    first_nxt  = toggle_r ? first_r : in_capture_count;
    second_nxt = toggle_r ? in_capture_count : second_r;
    period     = (second_nxt >= first_nxt) ? (second_nxt - first_nxt)
                                           : (first_nxt - second_nxt);
    reject     = (period >= max_period_r);

    op_sel     = OP_FINISH;
    add_sel    = 1'b0;
    slope_sel  = red_slope_r;
    offset_sel = red_offset_r;
    floor_sel  = red_floor_r;
    idx_nxt    = '0;
    if (idx_r < IDX_W'(HALF)) begin
      op_sel     = (idx_r == IDX_W'(HALF - 1)) ? OP_SWITCH : OP_GREEN;
      add_sel    = (idx_r >= IDX_W'(DISCARD));
      slope_sel  = green_slope_r;
      offset_sel = green_offset_r;
      floor_sel  = green_floor_r;
      idx_nxt    = idx_r + 1'b1;
    end else if (idx_r < IDX_W'(SAMPLES)) begin
      op_sel  = OP_RED;
      add_sel = (idx_r >= IDX_W'(HALF + DISCARD));
      idx_nxt = idx_r + 1'b1;
    end
    clamped = (period < floor_sel) ? floor_sel : period;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r    <= '0;
      second_r   <= '0;
      toggle_r   <= 1'b0;
      idx_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept && !reject;
      if (accept) begin
        first_r  <= first_nxt;
        second_r <= second_nxt;
        toggle_r <= !toggle_r;
        if (!reject) begin
          idx_r <= idx_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r     <= op_sel;
    s1_add_r    <= add_sel;
    s1_p_r      <= clamped;
    s1_slope_r  <= slope_sel;
    s1_offset_r <= offset_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_op_r     <= s1_op_r;
    s2_add_r    <= s1_add_r;
    s2_scaled_r <= (SUM_W'(s1_slope_r) * SUM_W'(s1_p_r)) + SUM_W'(s1_offset_r);
  end

  // stage 3: accumulate, emit events; finish sees sums of all earlier kept samples
  assign s2_green = (s2_op_r == OP_GREEN) || (s2_op_r == OP_SWITCH);

  always_comb begin
    green_sum_nxt = green_sum_r;
    red_sum_nxt   = red_sum_r;
    if (s2_valid_r) begin
      if (s2_op_r == OP_FINISH) begin
        green_sum_nxt = '0;
        red_sum_nxt   = '0;
      end else if (s2_add_r && s2_green) begin
        green_sum_nxt = green_sum_r + s2_scaled_r;
      end else if (s2_add_r) begin
        red_sum_nxt = red_sum_r + s2_scaled_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_sum_r <= '0;
      red_sum_r   <= '0;
    end else begin
      green_sum_r <= green_sum_nxt;
      red_sum_r   <= red_sum_nxt;
    end
  end

  assign ev_push           = s2_ev;
  assign ev_data.kind      = (s2_op_r == OP_FINISH) ? EVENT_FINISH : EVENT_SWITCH;
  assign ev_data.green_sum = green_sum_r;
  assign ev_data.red_sum   = red_sum_r;

endmodule
`default_nettype wire

### rtl/core/csmc_queue.sv
// small event queue between front and back parts
// depends on csmc_pkg for depth and entry type
`timescale 1ns / 1ps
`default_nettype none
module csmc_queue
  import csmc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire event_t push_data,
  input  wire logic   pop,
  output q_status_t   status,
  output event_t      head
);

  event_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  // front reserves room, so a push never meets a full queue
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.count = count_r;
  assign status.valid = (count_r != '0);

endmodule
`default_nettype wire

### rtl/core/csmc_div.sv
// division by a constant through a reciprocal multiply, split into half-width products
// depends on csmc_pkg for the sum width
`timescale 1ns / 1ps
`default_nettype none
module csmc_div
  import csmc_pkg::*;
#(
  parameter int DIVISOR = 6
) (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic             step,
  input  wire logic [SUM_W-1:0] dividend,
  output logic      [SUM_W-1:0] quotient
);

  localparam int HALF_W = SUM_W / 2;
  localparam int SHIFT  = SUM_W + $clog2(DIVISOR);
  localparam int PART_W = SUM_W + 1 + HALF_W;
  localparam int ACC_W  = SHIFT + SUM_W;
  localparam logic [63:0] ONE_SHIFTED = 64'd1 << SHIFT;
  // rounded-up reciprocal, exact floor for every dividend of SUM_W bits
  localparam logic [SUM_W:0] RECIP =
    (SUM_W + 1)'((ONE_SHIFTED + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [HALF_W-1:0] hi_r;
  logic [PART_W-1:0] lo_prod_r, hi_prod_r;
  logic [ACC_W-1:0]  acc_r;

  // load: low half product; first step: high half product; second step: the add
  always_ff @(posedge clk) begin
    if (load) begin
      hi_r      <= dividend[SUM_W-1:HALF_W];
      lo_prod_r <= PART_W'(RECIP) * PART_W'(dividend[HALF_W-1:0]);
    end
    if (step) begin
      hi_prod_r <= PART_W'(RECIP) * PART_W'(hi_r);
      acc_r     <= ACC_W'(lo_prod_r) + (ACC_W'(hi_prod_r) << HALF_W);
    end
  end

  assign quotient = acc_r[SHIFT +: SUM_W];

endmodule
`default_nettype wire

### rtl/core/csmc_back.sv
// back part: drains the event queue, divides sums into means, holds the result register
// depends on csmc_pkg and csmc_div
`timescale 1ns / 1ps
`default_nettype none
module csmc_back
  import csmc_pkg::*;
#(
  parameter int KEPT = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire q_status_t        q_status,
  input  wire event_t           q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_event_kind,
  output logic      [SUM_W-1:0] out_green_level,
  output logic      [SUM_W-1:0] out_red_level,
  output logic      [1:0]       out_verdict
);

  bk_state_t state_r, state_nxt;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 out_free;
  logic                 start_div, load_switch, load_finish, div_step;
  logic [SUM_W-1:0]     green_q, red_q;

  logic             out_valid_r;
  logic             out_kind_r;
  logic [SUM_W-1:0] out_green_r, out_red_r;
  logic [1:0]       out_verdict_r;
  logic [1:0]       verdict;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_status.valid && q_head.kind == EVENT_FINISH) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = BK_LOAD;
        end
      end
      BK_LOAD: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    start_div   = 1'b0;
    load_switch = 1'b0;
    load_finish = 1'b0;
    div_step    = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_status.valid && q_head.kind == EVENT_FINISH) begin
          start_div = 1'b1;
        end else if (q_status.valid && out_free) begin
          load_switch = 1'b1;
        end
      end
      BK_DIV:  div_step    = 1'b1;
      BK_LOAD: load_finish = out_free;
      default: ;
    endcase
  end

  assign q_pop = start_div || load_switch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (start_div) begin
        cnt_r <= '0;
      end else if (div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  csmc_div #(.DIVISOR(KEPT)) u_div_green (
    .clk      (clk),
    .load     (start_div),
    .step     (div_step),
    .dividend (q_head.green_sum),
    .quotient (green_q)
  );

  csmc_div #(.DIVISOR(KEPT)) u_div_red (
    .clk      (clk),
    .load     (start_div),
    .step     (div_step),
    .dividend (q_head.red_sum),
    .quotient (red_q)
  );

  always_comb begin
    if (green_q < red_q) begin
      verdict = VERDICT_GREEN;
    end else if (green_q == red_q) begin
      verdict = VERDICT_AGAIN;
    end else begin
      verdict = VERDICT_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_switch || load_finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_switch) begin
      out_kind_r    <= EVENT_SWITCH;
      out_green_r   <= '0;
      out_red_r     <= '0;
      out_verdict_r <= VERDICT_GREEN;
    end else if (load_finish) begin
      out_kind_r    <= EVENT_FINISH;
      out_green_r   <= green_q;
      out_red_r     <= red_q;
      out_verdict_r <= verdict;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_green_level = out_green_r;
  assign out_red_level   = out_red_r;
  assign out_verdict     = out_verdict_r;

endmodule
`default_nettype wire

### rtl/core/color_sensor_measure_classify.sv
// top level of the color sensor measure/classify block
// depends on csmc_pkg, csmc_front, csmc_queue, csmc_back
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_capture_count
//   out_     output     out_valid/out_stall  event_kind, green_level, red_level, verdict
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one capture count is taken every cycle while in_stall is low; a result then passes
// stage 1, stage 2, the queue and the output register, a finish also the mean multiply
// in_stall rises only when the 4-entry event queue plus events still in flight is full
// synchronous active-low reset; no clearing pass, the block is ready right after reset
`timescale 1ns / 1ps
`default_nettype none
module color_sensor_measure_classify
  import csmc_pkg::*;
#(
  parameter int SAMPLES = 16,
  parameter int DISCARD = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [REG_W-1:0]     in_capture_count,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_event_kind,
  output logic      [SUM_W-1:0]     out_green_level,
  output logic      [SUM_W-1:0]     out_red_level,
  output logic      [1:0]           out_verdict,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data
);

  localparam int KEPT = SAMPLES / 2 - DISCARD;

  q_status_t q_status;
  event_t    ev_data, q_head;
  logic      ev_push, q_pop;

  csmc_front #(.SAMPLES(SAMPLES), .DISCARD(DISCARD)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_capture_count (in_capture_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_status         (q_status),
    .ev_push          (ev_push),
    .ev_data          (ev_data)
  );

  csmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .push_data (ev_data),
    .pop       (q_pop),
    .status    (q_status),
    .head      (q_head)
  );

  csmc_back #(.KEPT(KEPT)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_green_level (out_green_level),
    .out_red_level   (out_red_level),
    .out_verdict     (out_verdict)
  );

endmodule
`default_nettype wire

### tb/sv/color_sensor_measure_classify_tb.sv
// self-checking testbench for color_sensor_measure_classify
// uses csmc_pkg for register indexes, reset values, event and verdict codes
// predicts every event from a cycle-free model of the capture/scale/average flow
`timescale 1ns / 1ps
module color_sensor_measure_classify_tb;
  import csmc_pkg::*;

  localparam int SAMPLES         = 16;
  localparam int DISCARD         = 2;
  localparam int HALF_RUN        = SAMPLES / 2;
  localparam int KEPT_PER_HALF   = HALF_RUN - DISCARD;
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 1200;
  localparam int WATCHDOG_LIMIT  = 8000;
  localparam int SETTING_COUNT   = 10;

  typedef struct packed {
    logic             kind;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
    logic [1:0]       verdict;
  } sensor_event_t;

  typedef struct {
    logic [REG_W-1:0] max_period;
    logic [REG_W-1:0] green_slope;
    logic [REG_W-1:0] green_offset;
    logic [REG_W-1:0] green_floor;
    logic [REG_W-1:0] red_slope;
    logic [REG_W-1:0] red_offset;
    logic [REG_W-1:0] red_floor;
  } sensor_cfg_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [REG_W-1:0]     in_capture_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_event_kind;
  logic [SUM_W-1:0]     out_green_level;
  logic [SUM_W-1:0]     out_red_level;
  logic [1:0]           out_verdict;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_PERIOD;
  logic [REG_W-1:0]     cfg_data = '0;

  color_sensor_measure_classify #(
    .SAMPLES(SAMPLES),
    .DISCARD(DISCARD)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_capture_count (in_capture_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_green_level  (out_green_level),
    .out_red_level    (out_red_level),
    .out_verdict      (out_verdict),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  // register copy used by the predictor
  logic [REG_W-1:0] shadow_regs [0:6];

  // predictor state
  logic [REG_W-1:0] stamp_first  = '0;
  logic [REG_W-1:0] stamp_second = '0;
  logic             stamp_sel    = 1'b0;
  int unsigned      run_pos      = 0;
  logic [SUM_W-1:0] green_acc    = '0;
  logic [SUM_W-1:0] red_acc      = '0;

  logic [REG_W-1:0] capture_backlog [$];
  sensor_event_t    expected_events [$];

  logic calm          = 1'b0;
  logic pressure_arm  = 1'b0;
  logic pressure_done = 1'b0;
  int   send_gap      = 0;
  int   stall_left    = 0;
  int   hold_left     = 0;
  int   idle_cycles   = 0;
  int   mismatch_count = 0;
  int   captures_sent  = 0;
  int   switch_seen    = 0;
  int   finish_seen    = 0;
  int   verdict_seen [0:2] = '{0, 0, 0};

  function automatic logic [15:0] rnd16(int unsigned lo, int unsigned hi);
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic logic [SUM_W-1:0] scaled_level(logic [REG_W-1:0] period,
                                                    logic [REG_W-1:0] slope,
                                                    logic [REG_W-1:0] offset,
                                                    logic [REG_W-1:0] floor_v);
    logic [SUM_W-1:0] p;
    p = (period < floor_v) ? {16'd0, floor_v} : {16'd0, period};
    return {16'd0, slope} * p + {16'd0, offset};
  endfunction

  function automatic void predict_capture(logic [REG_W-1:0] count);
    logic [REG_W-1:0] period;
    logic [SUM_W-1:0] scaled;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] r;
    sensor_event_t    ev;
    if (!stamp_sel) stamp_first = count;
    else stamp_second = count;
    stamp_sel = ~stamp_sel;
    period = (stamp_second >= stamp_first) ? stamp_second - stamp_first
                                           : stamp_first - stamp_second;
    if (period >= shadow_regs[CFG_MAX_PERIOD]) return;
    if (run_pos < HALF_RUN) begin
      scaled = scaled_level(period, shadow_regs[CFG_GREEN_SLOPE],
                            shadow_regs[CFG_GREEN_OFFSET], shadow_regs[CFG_GREEN_FLOOR]);
      if (run_pos >= DISCARD) green_acc = green_acc + scaled;
      run_pos++;
      if (run_pos == HALF_RUN) begin
        ev = '{kind: EVENT_SWITCH, green: '0, red: '0, verdict: '0};
        expected_events.push_back(ev);
      end
    end else if (run_pos < SAMPLES) begin
      scaled = scaled_level(period, shadow_regs[CFG_RED_SLOPE],
                            shadow_regs[CFG_RED_OFFSET], shadow_regs[CFG_RED_FLOOR]);
      if (run_pos >= HALF_RUN + DISCARD) red_acc = red_acc + scaled;
      run_pos++;
    end else begin
      // run full: this sample only closes it
      g = green_acc / SUM_W'(KEPT_PER_HALF);
      r = red_acc / SUM_W'(KEPT_PER_HALF);
      ev.kind    = EVENT_FINISH;
      ev.green   = g;
      ev.red     = r;
      ev.verdict = (g < r) ? VERDICT_GREEN : ((g == r) ? VERDICT_AGAIN : VERDICT_RED);
      expected_events.push_back(ev);
      run_pos   = 0;
      green_acc = '0;
      red_acc   = '0;
    end
  endfunction

  function automatic void check_field(string name, logic [SUM_W-1:0] want,
                                      logic [SUM_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // capture driver
  always @(posedge clk) begin : driver
    int roll;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_capture(in_capture_count);
        captures_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (capture_backlog.size() > 0) begin
          in_valid <= 1'b1;
          in_capture_count <= capture_backlog.pop_front();
          roll = $urandom_range(99, 0);
          if (calm || roll < 55) send_gap = 0;
          else if (roll < 92) send_gap = $urandom_range(3, 1);
          else send_gap = $urandom_range(60, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // event monitor and receiver stall
  always @(posedge clk) begin : monitor
    sensor_event_t want;
    int roll;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("event with no prediction pending: kind %0d", out_event_kind);
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", SUM_W'(want.kind), SUM_W'(out_event_kind));
          check_field("green_level", want.green, out_green_level);
          check_field("red_level", want.red, out_red_level);
          check_field("verdict", SUM_W'(want.verdict), SUM_W'(out_verdict));
          if (want.kind == EVENT_SWITCH) switch_seen++;
          else begin
            finish_seen++;
            if (want.verdict <= VERDICT_AGAIN) verdict_seen[want.verdict]++;
          end
        end
      end
      // one long hold-off so the event queue backs up into the input
      if (pressure_arm && !pressure_done && out_valid) begin
        hold_left = HOLD_OFF_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_left == 0 && !calm) begin
          roll = $urandom_range(99, 0);
          if (roll >= 92) stall_left = $urandom_range(60, 15);
          else if (roll >= 60) stall_left = $urandom_range(3, 1);
        end
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // ends the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    shadow_regs[idx] = val;
  endtask

  task automatic apply_settings(sensor_cfg_t s);
    write_reg(CFG_MAX_PERIOD, s.max_period);
    write_reg(CFG_GREEN_SLOPE, s.green_slope);
    write_reg(CFG_GREEN_OFFSET, s.green_offset);
    write_reg(CFG_GREEN_FLOOR, s.green_floor);
    write_reg(CFG_RED_SLOPE, s.red_slope);
    write_reg(CFG_RED_OFFSET, s.red_offset);
    write_reg(CFG_RED_FLOOR, s.red_floor);
    cfg_valid <= 1'b0;
  endtask

  // waits for every capture and event, then lets trailing work finish
  task automatic wait_drained();
    do @(posedge clk);
    while (capture_backlog.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sensor_cfg_t      s;
    int               item_total;
    int               roll;
    int               delta;
    int               up;
    logic [REG_W-1:0] count;

    shadow_regs[CFG_MAX_PERIOD]   = RST_MAX_PERIOD;
    shadow_regs[CFG_GREEN_SLOPE]  = RST_SLOPE;
    shadow_regs[CFG_GREEN_OFFSET] = RST_OFFSET;
    shadow_regs[CFG_GREEN_FLOOR]  = RST_FLOOR;
    shadow_regs[CFG_RED_SLOPE]    = RST_SLOPE;
    shadow_regs[CFG_RED_OFFSET]   = RST_OFFSET;
    shadow_regs[CFG_RED_FLOOR]    = RST_FLOOR;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first edge period is the count itself, zero periods hit the
    // floor, periods at the limit are dropped, and a full run closes with a finish
    capture_backlog = '{16'd1000, 16'd1000, 16'd0, 16'd65535, 16'd65535, 16'd15536,
                        16'd65535, 16'd15535, 16'd100, 16'd200, 16'd300, 16'd400,
                        16'd500, 16'd600, 16'd700, 16'd800, 16'd900, 16'd1000,
                        16'd1100, 16'd1200, 16'd1300, 16'd1400, 16'd1500, 16'd1600,
                        16'd1700};
    count = 16'd1700;
    wait_drained();

    for (int setting = 0; setting < SETTING_COUNT; setting++) begin
      calm = 1'b0;
      item_total = 200;
      case (setting)
        0: begin
          s = '{16'd50000, rnd16(0, 300), rnd16(0, 65535), rnd16(0, 2000),
                rnd16(0, 300), rnd16(0, 65535), rnd16(0, 2000)};
          item_total = 450;
          pressure_arm = 1'b1;
        end
        1: begin
          s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
          item_total = 150;
        end
        2: begin
          // nothing passes a zero limit
          s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
          item_total = 40;
        end
        3: begin
          s = '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
          item_total = 150;
          calm = 1'b1;
        end
        4: begin
          // only repeated counts give a period below one
          s = '{16'd1, rnd16(0, 65535), rnd16(0, 65535), rnd16(0, 65535),
                rnd16(0, 65535), rnd16(0, 65535), rnd16(0, 65535)};
          item_total = 150;
        end
        5: s = '{16'd50000, 16'd1000, rnd16(0, 65535), 16'd0,
                 16'd10, rnd16(0, 65535), 16'd0};
        6: s = '{16'd50000, 16'd10, rnd16(0, 65535), 16'd0,
                 16'd1000, rnd16(0, 65535), 16'd0};
        default: s = '{rnd16(100, 65535), rnd16(0, 65535), rnd16(0, 65535),
                       rnd16(0, 65535), rnd16(0, 65535), rnd16(0, 65535),
                       rnd16(0, 65535)};
      endcase
      apply_settings(s);

      for (int n = 0; n < item_total; n++) begin
        roll = $urandom_range(99, 0);
        if (roll < 5 || s.max_period == 0) begin
          count = 16'($urandom);
        end else begin
          if (roll < 12 || (s.max_period <= 1 && roll < 80)) delta = 0;
          else if (roll < 18) delta = int'(s.max_period) - int'($urandom_range(1, 0));
          else if (roll < 30) delta = $urandom_range(16, 1);
          else if (s.max_period > 1) delta = $urandom_range(int'(s.max_period) - 1, 1);
          else delta = 1;
          // step up or down on the timer, mostly without wrapping
          up = $urandom_range(1, 0);
          if (up == 1 && int'(count) + delta > 65535) up = 0;
          else if (up == 0 && int'(count) < delta) up = 1;
          count = (up == 1) ? 16'(int'(count) + delta) : 16'(int'(count) - delta);
        end
        capture_backlog.push_back(count);
      end
      wait_drained();
    end

    $display("run covered %0d captures over %0d register settings: %0d filter switches, %0d finished runs",
             captures_sent, SETTING_COUNT + 1, switch_seen, finish_seen);
    $display("verdicts seen: green %0d, red %0d, measure again %0d",
             verdict_seen[VERDICT_GREEN], verdict_seen[VERDICT_RED],
             verdict_seen[VERDICT_AGAIN]);
    if (mismatch_count == 0 && expected_events.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### color_sensor_measure_classify.f
rtl/core/csmc_pkg.sv
rtl/core/csmc_front.sv
rtl/core/csmc_queue.sv
rtl/core/csmc_div.sv
rtl/core/csmc_back.sv
rtl/core/color_sensor_measure_classify.sv
tb/sv/color_sensor_measure_classify_tb.sv
